### rtl/rbd_pkg.sv
// Shared types and constants for the residual block decompressor.
`default_nettype none
package rbd_pkg;

    localparam int MAX_SAMPLES      = 1024;
    localparam int MAX_CHANNELS     = 256;
    localparam int RESULTS_PER_ITEM = 8;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_METHOD   = 3'd1;
    localparam logic [2:0] ERR_INTERCH  = 3'd2;
    localparam logic [2:0] ERR_LENGTH   = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    localparam logic CFG_SAMPLES  = 1'b0;
    localparam logic CFG_CHANNELS = 1'b1;

    typedef enum logic [1:0] {
        IK_BYTE,
        IK_TICK,
        IK_START
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  data;
    } item_t;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_METHOD,
        PH_SKIP,
        PH_STD,
        PH_EXT,
        PH_FIRST,
        PH_RESID,
        PH_ESC
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FIN
    } core_state_t;

endpackage
`default_nettype wire

### rtl/residual_block_decompressor_top.sv
// Top level of the residual block decompressor.
//
//  channel   handshake             payload
//  in        in_valid/in_ready     kind, data_byte
//  out       out_valid/out_ready   sample_value, channel_number, sample_number,
//                                  block_done, error_code
//  cfg       cfg_wr_en             cfg_index, cfg_data
//
// An item leaves the queue in the idle state and its decoding ends in the step state;
// each parsed field takes a step, and a decoded sample one more in the finish state for
// line memory read and integration. Escapes, channel headers and result register stalls
// add steps.
// Reset leaves the decoder waiting for a block start; the line memory is not cleared.
// A two-item input queue keeps accepting, until it is full, while the decoder is busy or the
// result register is stalled.
`default_nettype none
module residual_block_decompressor_top (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_wr_en,
    input  wire                 cfg_index,
    input  wire  [10:0]         cfg_data,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [1:0]          kind,
    input  wire  [7:0]          data_byte,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic signed [31:0]  sample_value,
    output logic [7:0]          channel_number,
    output logic [9:0]          sample_number,
    output logic                block_done,
    output logic [2:0]          error_code
);

    logic           q_valid;
    rbd_pkg::item_t q_item;
    logic           q_pop;

    rbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    rbd_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_value   (sample_value),
        .channel_number (channel_number),
        .sample_number  (sample_number),
        .block_done     (block_done),
        .error_code     (error_code)
    );

endmodule
`default_nettype wire

### rtl/rbd_front.sv
// Input front end: classifies items and queues them for the decoder.
`default_nettype none
module rbd_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [1:0]          kind,
    input  wire  [7:0]          data_byte,
    output logic                q_valid,
    output rbd_pkg::item_t      q_item,
    input  wire                 q_pop
);

    rbd_pkg::item_t entry_reg [rbd_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    rbd_pkg::item_t new_item;
    logic           push;
    logic           pop;

    always_comb
    begin
        new_item.data = data_byte;
        case (kind)
            rbd_pkg::KIND_DATA:  new_item.kind = rbd_pkg::IK_BYTE;
            rbd_pkg::KIND_START: new_item.kind = rbd_pkg::IK_START;
            default:             new_item.kind = rbd_pkg::IK_TICK;
        endcase
    end

    assign in_ready = (count_reg != 2'(rbd_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule
`default_nettype wire

### rtl/rbd_core.sv
// Decoder back end: bit buffer, field parser, integrator and result register.
`default_nettype none
module rbd_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_wr_en,
    input  wire                 cfg_index,
    input  wire  [10:0]         cfg_data,
    input  wire                 q_valid,
    input  rbd_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic signed [31:0]  sample_value,
    output logic [7:0]          channel_number,
    output logic [9:0]          sample_number,
    output logic                block_done,
    output logic [2:0]          error_code
);

    function automatic logic [31:0] sext(input logic [31:0] v, input logic [5:0] len);
        logic [31:0] mask;
        logic [31:0] res;
        mask = (len == 6'd0) ? 32'd0 : 32'((33'd1 << len) - 33'd1);
        res  = v & mask;
        if (len != 6'd0 && v[5'(len - 6'd1)])
        begin
            res = res | ~mask;
        end
        return res;
    endfunction

    rbd_pkg::core_state_t state_reg, state_next;
    rbd_pkg::phase_t      phase_reg, phase_next;
    logic [10:0] spc_reg, spc_next;
    logic [8:0]  chc_reg, chc_next;
    logic [63:0] buf_reg, buf_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [3:0]  method_reg, method_next;
    logic [5:0]  std_reg, std_next;
    logic [5:0]  ext_reg, ext_next;
    logic [7:0]  ch_reg, ch_next;
    logic [9:0]  sc_reg, sc_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] second_reg, second_next;
    logic [31:0] prior_reg, prior_next;
    logic [31:0] r_reg, r_next;
    logic [3:0]  k_reg, k_next;

    logic        ov_reg, ov_next;
    logic [31:0] ov_value_reg, ov_value_next;
    logic [7:0]  ov_ch_reg, ov_ch_next;
    logic [9:0]  ov_sc_reg, ov_sc_next;
    logic        ov_done_reg, ov_done_next;
    logic [2:0]  ov_err_reg, ov_err_next;

    logic [31:0] line_mem [rbd_pkg::MAX_SAMPLES];
    logic [31:0] rdata_reg;
    logic        mem_we;

    logic        out_free;
    logic [5:0]  mbit;
    logic [5:0]  dbit;
    logic [5:0]  need;
    logic [6:0]  rest;
    logic [63:0] shifted;
    logic [31:0] take;
    logic [63:0] rest_buf;
    logic [10:0] eff_s;
    logic [8:0]  eff_c;
    logic [2:0]  m;
    logic [31:0] v;
    logic [6:0]  cnt_al;
    logic        emit;
    logic [31:0] e_value;
    logic        e_done;
    logic [2:0]  e_err;

    assign out_free = !ov_reg || out_ready;
    assign mbit = method_reg[3] ? 6'd6 : 6'd4;
    assign dbit = method_reg[3] ? 6'd32 : 6'd16;
    assign m    = method_reg[2:0];

    always_comb
    begin
        case (phase_reg)
            rbd_pkg::PH_METHOD: need = 6'd4;
            rbd_pkg::PH_SKIP:   need = 6'd4;
            rbd_pkg::PH_STD:    need = mbit;
            rbd_pkg::PH_EXT:    need = mbit;
            rbd_pkg::PH_FIRST:  need = dbit;
            rbd_pkg::PH_RESID:  need = std_reg;
            rbd_pkg::PH_ESC:    need = ext_reg;
            default:            need = 6'd0;
        endcase
        rest     = cnt_reg - 7'(need);
        shifted  = buf_reg >> rest;
        take     = (need == 6'd0) ? 32'd0
                 : shifted[31:0] & 32'((33'd1 << need) - 33'd1);
        rest_buf = buf_reg & 64'((65'd1 << rest) - 65'd1);
        if (spc_reg == 11'd0)
            eff_s = 11'd1;
        else if (spc_reg > 11'(rbd_pkg::MAX_SAMPLES))
            eff_s = 11'(rbd_pkg::MAX_SAMPLES);
        else
            eff_s = spc_reg;
        if (chc_reg == 9'd0)
            eff_c = 9'd1;
        else if (chc_reg > 9'(rbd_pkg::MAX_CHANNELS))
            eff_c = 9'(rbd_pkg::MAX_CHANNELS);
        else
            eff_c = chc_reg;
        cnt_al = {cnt_reg[6:3], 3'b000};
        v = r_reg;
        if (sc_reg != 10'd0)
        begin
            case (m)
                3'd1: v = r_reg + last_reg;
                3'd2: v = (sc_reg == 10'd1) ? r_reg + last_reg
                        : r_reg + last_reg + (last_reg - second_reg);
                3'd3: v = r_reg + last_reg + (rdata_reg - prior_reg);
                default: v = r_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        spc_next    = spc_reg;
        chc_next    = chc_reg;
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        method_next = method_reg;
        std_next    = std_reg;
        ext_next    = ext_reg;
        ch_next     = ch_reg;
        sc_next     = sc_reg;
        last_next   = last_reg;
        second_next = second_reg;
        prior_next  = prior_reg;
        r_next      = r_reg;
        k_next      = k_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        emit        = 1'b0;
        e_value     = 32'd0;
        e_done      = 1'b1;
        e_err       = rbd_pkg::ERR_NONE;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                rbd_pkg::CFG_SAMPLES:  spc_next = cfg_data;
                rbd_pkg::CFG_CHANNELS: chc_next = cfg_data[8:0];
                default: ;
            endcase
        end

        case (state_reg)
            rbd_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop  = 1'b1;
                    k_next = 4'd0;
                    if (q_item.kind == rbd_pkg::IK_START)
                    begin
                        buf_next    = 64'd0;
                        cnt_next    = 7'd0;
                        phase_next  = rbd_pkg::PH_METHOD;
                        method_next = 4'd0;
                        std_next    = 6'd0;
                        ext_next    = 6'd0;
                        ch_next     = 8'd0;
                        sc_next     = 10'd0;
                        last_next   = 32'd0;
                        second_next = 32'd0;
                        prior_next  = 32'd0;
                    end
                    else if (phase_reg != rbd_pkg::PH_WAIT)
                    begin
                        if (q_item.kind == rbd_pkg::IK_BYTE)
                        begin
                            if (cnt_reg > 7'd56)
                            begin
                                emit       = 1'b1;
                                e_err      = rbd_pkg::ERR_OVERFLOW;
                                phase_next = rbd_pkg::PH_WAIT;
                            end
                            else
                            begin
                                buf_next   = {buf_reg[55:0], q_item.data};
                                cnt_next   = cnt_reg + 7'd8;
                                state_next = rbd_pkg::ST_STEP;
                            end
                        end
                        else
                        begin
                            state_next = rbd_pkg::ST_STEP;
                        end
                    end
                end
            end

            rbd_pkg::ST_STEP:
            begin
                if (k_reg == 4'(rbd_pkg::RESULTS_PER_ITEM) ||
                    phase_reg == rbd_pkg::PH_WAIT || cnt_reg < 7'(need))
                begin
                    state_next = rbd_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    buf_next = rest_buf;
                    cnt_next = rest;
                    case (phase_reg)
                        rbd_pkg::PH_METHOD:
                        begin
                            method_next = take[3:0];
                            if (take[2:0] > 3'd3)
                            begin
                                emit  = 1'b1;
                                e_err = rbd_pkg::ERR_METHOD;
                            end
                            else if (ch_reg == 8'd0 && take[2:0] == 3'd3)
                            begin
                                emit  = 1'b1;
                                e_err = rbd_pkg::ERR_INTERCH;
                            end
                            else if (take[2:0] == 3'd0)
                            begin
                                std_next   = take[3] ? 6'd32 : 6'd16;
                                ext_next   = 6'd0;
                                phase_next = rbd_pkg::PH_SKIP;
                            end
                            else
                            begin
                                phase_next = rbd_pkg::PH_STD;
                            end
                        end
                        rbd_pkg::PH_SKIP:
                        begin
                            phase_next = rbd_pkg::PH_FIRST;
                        end
                        rbd_pkg::PH_STD:
                        begin
                            std_next = take[5:0];
                            if (take[5:0] > 6'd32)
                            begin
                                emit  = 1'b1;
                                e_err = rbd_pkg::ERR_LENGTH;
                            end
                            else
                            begin
                                phase_next = rbd_pkg::PH_EXT;
                            end
                        end
                        rbd_pkg::PH_EXT:
                        begin
                            ext_next = (take[5:0] == std_reg) ? 6'd0 : take[5:0];
                            if (take[5:0] > 6'd32)
                            begin
                                emit  = 1'b1;
                                e_err = rbd_pkg::ERR_LENGTH;
                            end
                            else
                            begin
                                phase_next = rbd_pkg::PH_FIRST;
                            end
                        end
                        rbd_pkg::PH_FIRST:
                        begin
                            r_next     = sext(take, dbit);
                            state_next = rbd_pkg::ST_FIN;
                        end
                        rbd_pkg::PH_RESID:
                        begin
                            if (ext_reg != 6'd0 && std_reg != 6'd0 &&
                                take == (32'd1 << (std_reg - 6'd1)))
                            begin
                                phase_next = rbd_pkg::PH_ESC;
                            end
                            else
                            begin
                                r_next     = sext(take, std_reg);
                                state_next = rbd_pkg::ST_FIN;
                            end
                        end
                        rbd_pkg::PH_ESC:
                        begin
                            r_next     = sext(take, ext_reg);
                            state_next = rbd_pkg::ST_FIN;
                        end
                        default:
                        begin
                            phase_next = rbd_pkg::PH_WAIT;
                        end
                    endcase
                    if (emit)
                    begin
                        phase_next = rbd_pkg::PH_WAIT;
                        state_next = rbd_pkg::ST_IDLE;
                    end
                end
            end

            rbd_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    mem_we      = 1'b1;
                    prior_next  = rdata_reg;
                    second_next = last_reg;
                    last_next   = v;
                    emit        = 1'b1;
                    e_value     = v;
                    e_done      = 1'b0;
                    k_next      = k_reg + 4'd1;
                    state_next  = rbd_pkg::ST_STEP;
                    if ({1'b0, sc_reg} + 11'd1 >= eff_s)
                    begin
                        cnt_next = cnt_al;
                        buf_next = buf_reg & 64'((65'd1 << cnt_al) - 65'd1);
                        if ({1'b0, ch_reg} + 9'd1 >= eff_c)
                        begin
                            e_done     = 1'b1;
                            phase_next = rbd_pkg::PH_WAIT;
                        end
                        else
                        begin
                            phase_next = rbd_pkg::PH_METHOD;
                            ch_next    = ch_reg + 8'd1;
                            sc_next    = 10'd0;
                        end
                    end
                    else
                    begin
                        phase_next = rbd_pkg::PH_RESID;
                        sc_next    = sc_reg + 10'd1;
                    end
                end
            end

            default:
            begin
                state_next = rbd_pkg::ST_IDLE;
            end
        endcase

        ov_next       = emit ? 1'b1 : (ov_reg && !out_ready);
        ov_value_next = emit ? e_value : ov_value_reg;
        ov_ch_next    = emit ? ch_reg : ov_ch_reg;
        ov_sc_next    = emit ? sc_reg : ov_sc_reg;
        ov_done_next  = emit ? e_done : ov_done_reg;
        ov_err_next   = emit ? e_err : ov_err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rbd_pkg::ST_IDLE;
            phase_reg  <= rbd_pkg::PH_WAIT;
            spc_reg    <= 11'd64;
            chc_reg    <= 9'd1;
            buf_reg    <= 64'd0;
            cnt_reg    <= 7'd0;
            method_reg <= 4'd0;
            std_reg    <= 6'd0;
            ext_reg    <= 6'd0;
            ch_reg     <= 8'd0;
            sc_reg     <= 10'd0;
            last_reg   <= 32'd0;
            second_reg <= 32'd0;
            prior_reg  <= 32'd0;
            k_reg      <= 4'd0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            spc_reg    <= spc_next;
            chc_reg    <= chc_next;
            buf_reg    <= buf_next;
            cnt_reg    <= cnt_next;
            method_reg <= method_next;
            std_reg    <= std_next;
            ext_reg    <= ext_next;
            ch_reg     <= ch_next;
            sc_reg     <= sc_next;
            last_reg   <= last_next;
            second_reg <= second_next;
            prior_reg  <= prior_next;
            k_reg      <= k_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        ov_value_reg <= ov_value_next;
        ov_ch_reg    <= ov_ch_next;
        ov_sc_reg    <= ov_sc_next;
        ov_done_reg  <= ov_done_next;
        ov_err_reg   <= ov_err_next;
    end

    // previous-channel line; read address follows the sample counter
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[sc_reg] <= v;
        end
        rdata_reg <= line_mem[sc_reg];
    end

    assign out_valid      = ov_reg;
    assign sample_value   = ov_value_reg;
    assign channel_number = ov_ch_reg;
    assign sample_number  = ov_sc_reg;
    assign block_done     = ov_done_reg;
    assign error_code     = ov_err_reg;

endmodule
`default_nettype wire
